### rtl/fxalu_pkg.sv
// Package: command codes, widths and shared types for the fixed-point ALU.
`timescale 1ns / 1ps
package fxalu_pkg;

    localparam int DataWidth = 32;
    localparam int FractionBitsDefault = 8;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_CMP      = 4'd4,
        CMD_MIN      = 4'd5,
        CMD_MAX      = 4'd6,
        CMD_INC      = 4'd7,
        CMD_DEC      = 4'd8,
        CMD_TO_INT   = 4'd9,
        CMD_FROM_INT = 4'd10
    } cmd_t;

    // Per-beat control that travels down the pipeline with the data.
    typedef struct packed {
        logic       valid;
        logic [3:0] command;
        logic       neg;
    } ctl_t;

    // Result flags of one beat.
    typedef struct packed {
        logic is_less;
        logic is_equal;
        logic is_greater;
        logic overflowed;
        logic divide_by_zero;
    } flags_t;

endpackage

### rtl/fxalu_div.sv
// Pipelined radix-2 restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module fxalu_div #(
    parameter int NumWidth = 48,
    parameter int DenWidth = 33
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [NumWidth-1:0] num,
    input  logic [DenWidth-1:0] den,
    output logic                out_valid,
    output logic [NumWidth-1:0] quot
);
    localparam int RemWidth = DenWidth + 1;

    logic [NumWidth-1:0] q_reg   [NumWidth+1];
    logic [NumWidth-1:0] n_reg   [NumWidth+1];
    logic [RemWidth-1:0] r_reg   [NumWidth+1];
    logic [DenWidth-1:0] d_reg   [NumWidth+1];
    logic                v_reg   [NumWidth+1];

    // Stage 0 entry.
    always_comb
    begin
        q_reg[0] = '0;
        n_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
        v_reg[0] = in_valid;
    end

    // One quotient bit per stage, MSB of the numerator first.
    for (genvar s = 0; s < NumWidth; s++) begin : g_stage
        logic [RemWidth-1:0] shifted;
        logic [RemWidth-1:0] diff;
        logic                take;
        always_comb
        begin
            shifted = {r_reg[s][RemWidth-2:0], n_reg[s][NumWidth-1]};
            diff    = shifted - {1'b0, d_reg[s]};
            take    = (shifted >= {1'b0, d_reg[s]});
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            q_reg[s+1] <= {q_reg[s][NumWidth-2:0], take};
            n_reg[s+1] <= {n_reg[s][NumWidth-2:0], 1'b0};
            r_reg[s+1] <= take ? diff : shifted;
            d_reg[s+1] <= d_reg[s];
        end
    end

    assign out_valid = v_reg[NumWidth];
    assign quot      = q_reg[NumWidth];
endmodule

### rtl/fxalu_fast.sv
// Fast path: add/sub, compares, min/max, inc/dec, conversions, multiply.
`timescale 1ns / 1ps
module fxalu_fast #(
    parameter int FractionBits = fxalu_pkg::FractionBitsDefault
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [3:0]                            command,
    input  logic signed [fxalu_pkg::DataWidth-1:0] operand_a,
    input  logic signed [fxalu_pkg::DataWidth-1:0] operand_b,
    output logic                                  out_valid,
    output logic signed [fxalu_pkg::DataWidth-1:0] out_value,
    output fxalu_pkg::flags_t                     out_flags
);
    import fxalu_pkg::*;

    localparam logic signed [33:0] SatMax = 34'sd2147483647;
    localparam logic signed [33:0] SatMin = -34'sd2147483648;

    // Stage 1: magnitudes, simple results.
    ctl_t                     c1_reg;
    logic [31:0]              ma_reg, mb_reg;
    logic signed [33:0]       s1_reg;
    logic                     sat1_reg;
    flags_t                   f1_reg;

    logic [31:0]              ma, mb;
    logic signed [33:0]       s1;
    logic                     sat1;
    flags_t                   f1;
    logic signed [63:0]       shl;

    always_comb
    begin
        ma   = operand_a[31] ? 32'(-operand_a) : operand_a;
        mb   = operand_b[31] ? 32'(-operand_b) : operand_b;
        s1   = '0;
        sat1 = 1'b1;
        f1   = '0;
        shl  = 64'(operand_a) <<< FractionBits;
        case (command)
            CMD_ADD:  s1 = 34'(operand_a) + 34'(operand_b);
            CMD_SUB:  s1 = 34'(operand_a) - 34'(operand_b);
            CMD_INC:  s1 = 34'(operand_a) + 34'sd1;
            CMD_DEC:  s1 = 34'(operand_a) - 34'sd1;
            CMD_CMP:
            begin
                f1.is_less    = operand_a < operand_b;
                f1.is_equal   = operand_a == operand_b;
                f1.is_greater = operand_a > operand_b;
            end
            CMD_MIN:  s1 = 34'(operand_a < operand_b ? operand_a : operand_b);
            CMD_MAX:  s1 = 34'(operand_a > operand_b ? operand_a : operand_b);
            CMD_TO_INT:
            begin
                s1 = operand_a[31] ? -34'(ma >> FractionBits) : 34'(ma >> FractionBits);
            end
            CMD_FROM_INT:
            begin
                if (shl > 64'(SatMax))      s1 = SatMax + 34'sd1;
                else if (shl < 64'(SatMin)) s1 = SatMin - 34'sd1;
                else                        s1 = 34'(shl);
            end
            default: sat1 = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c1_reg <= '0;
        else        c1_reg <= '{valid: in_valid, command: command,
                                neg: operand_a[31] ^ operand_b[31]};
    end

    always_ff @(posedge clk)
    begin
        ma_reg         <= ma;
        mb_reg         <= mb;
        s1_reg         <= s1;
        sat1_reg       <= sat1;
        f1_reg         <= f1;
    end

    // Stage 2: unsigned magnitude product.
    ctl_t               c2_reg;
    logic [63:0]        p2_reg;
    logic signed [33:0] s2_reg;
    flags_t             f2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c2_reg <= '0;
        else        c2_reg <= c1_reg;
    end

    always_ff @(posedge clk)
    begin
        p2_reg         <= 64'(ma_reg) * 64'(mb_reg);
        s2_reg         <= sat1_reg ? s1_reg : 34'sd0;
        f2_reg         <= f1_reg;
    end

    // Stage 3: rounding of the product.
    ctl_t        c3_reg;
    logic [63:0] q3_reg;
    logic signed [33:0] s3_reg;
    flags_t      f3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c3_reg <= '0;
        else        c3_reg <= c2_reg;
    end

    always_ff @(posedge clk)
    begin
        q3_reg <= (p2_reg + (64'd1 << (FractionBits - 1))) >> FractionBits;
        s3_reg <= s2_reg;
        f3_reg <= f2_reg;
    end

    // Stage 4: sign and saturation.
    logic signed [33:0] v4;
    logic               big;
    logic               ovf4;
    logic signed [31:0] r4;

    always_comb
    begin
        big  = |q3_reg[63:32];
        v4   = s3_reg;
        if (c3_reg.command == CMD_MUL)
        begin
            if (big) v4 = c3_reg.neg ? SatMin - 34'sd1 : SatMax + 34'sd1;
            else     v4 = c3_reg.neg ? -34'(q3_reg[32:0]) : 34'(q3_reg[32:0]);
        end
        ovf4 = (v4 > SatMax) || (v4 < SatMin);
        if (v4 > SatMax)      r4 = 32'sh7fffffff;
        else if (v4 < SatMin) r4 = 32'sh80000000;
        else                  r4 = 32'(v4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid <= 1'b0;
        else        out_valid <= c3_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        out_value <= r4;
        out_flags <= '{is_less: f3_reg.is_less, is_equal: f3_reg.is_equal,
                       is_greater: f3_reg.is_greater, overflowed: ovf4,
                       divide_by_zero: f3_reg.divide_by_zero};
    end
endmodule

### rtl/fixed_point_q24_8_alu_unit.sv
// Top level of the signed fixed-point ALU.
`timescale 1ns / 1ps
// Usage:
//   Drive command, operand_a and operand_b and pulse start; a beat is taken
//   on every edge with start high (busy is tied low, so one beat per cycle).
//   Each beat yields exactly one result, shown for one cycle with done high.
//   Results leave in issue order. Every command goes through the same
//   pipeline: the divider sets the depth, and fast commands are delayed
//   to match. Throughput is one beat per cycle.
//   The divider is a chain of one-bit restoring stages over a
//   (32 + FRACTION_BITS + 2)-bit doubled numerator.
//   Reset clears all valid bits; no result appears until a beat enters.
//   The receiver cannot stall; done must be taken when shown.
module fixed_point_q24_8_alu_unit #(
    parameter int FRACTION_BITS = fxalu_pkg::FractionBitsDefault
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [3:0]                            command,
    input  logic signed [fxalu_pkg::DataWidth-1:0] operand_a,
    input  logic signed [fxalu_pkg::DataWidth-1:0] operand_b,
    output logic                                  done,
    output logic signed [fxalu_pkg::DataWidth-1:0] result_value,
    output logic                                  is_less,
    output logic                                  is_equal,
    output logic                                  is_greater,
    output logic                                  overflowed,
    output logic                                  divide_by_zero
);
    import fxalu_pkg::*;

    // Doubled numerator 2*|a|<<F + |b| needs 32+F+2 bits; divisor 2*|b|.
    localparam int NumW   = 32 + FRACTION_BITS + 2;
    localparam int DenW   = 34;
    localparam int FastLat = 4;
    localparam int Delay  = NumW + 1 - FastLat;

    assign busy = 1'b0;

    logic accept;
    assign accept = start;

    // Fast path.
    logic               f_valid;
    logic signed [31:0] f_value;
    flags_t             f_flags;

    fxalu_fast #(.FractionBits(FRACTION_BITS)) u_fast (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (f_valid),
        .out_value (f_value),
        .out_flags (f_flags)
    );

    // Divider operand prep, registered.
    logic [31:0]     ma, mb;
    logic [NumW-1:0] num_reg;
    logic [DenW-1:0] den_reg;
    logic            dv_reg;

    always_comb
    begin
        ma = operand_a[31] ? 32'(-operand_a) : operand_a;
        mb = operand_b[31] ? 32'(-operand_b) : operand_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dv_reg <= 1'b0;
        else        dv_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= (NumW'(ma) << (FRACTION_BITS + 1)) + NumW'(mb);
        den_reg <= {1'b0, mb, 1'b0};
    end

    logic            d_valid;
    logic [NumW-1:0] d_quot;

    fxalu_div #(.NumWidth(NumW), .DenWidth(DenW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_reg),
        .num       (num_reg),
        .den       (den_reg),
        .out_valid (d_valid),
        .quot      (d_quot)
    );

    // Delay line for fast results and divide control.
    logic [31:0] dl_val_reg  [Delay];
    flags_t      dl_flg_reg  [Delay];
    logic [3:0]  dl_cmd_reg  [NumW+1];
    logic        dl_neg_reg  [NumW+1];
    logic        dl_bz_reg   [NumW+1];

    always_ff @(posedge clk)
    begin
        dl_val_reg[0] <= f_value;
        dl_flg_reg[0] <= f_flags;
        for (int i = 1; i < Delay; i++)
        begin
            dl_val_reg[i] <= dl_val_reg[i-1];
            dl_flg_reg[i] <= dl_flg_reg[i-1];
        end
        dl_cmd_reg[0] <= command;
        dl_neg_reg[0] <= operand_a[31] ^ operand_b[31];
        dl_bz_reg[0]  <= (operand_b == '0);
        for (int i = 1; i <= NumW; i++)
        begin
            dl_cmd_reg[i] <= dl_cmd_reg[i-1];
            dl_neg_reg[i] <= dl_neg_reg[i-1];
            dl_bz_reg[i]  <= dl_bz_reg[i-1];
        end
    end

    // Final merge: sign and saturate divide quotient, pick path.
    logic        big;
    logic signed [33:0] dv;
    logic signed [31:0] dres;
    logic        dovf;
    logic        is_div;

    always_comb
    begin
        is_div = (dl_cmd_reg[NumW] == CMD_DIV);
        big    = |(d_quot >> 32);
        if (big) dv = dl_neg_reg[NumW] ? -34'sd2147483649 : 34'sd2147483648;
        else     dv = dl_neg_reg[NumW] ? -34'(d_quot[31:0]) : 34'(d_quot[31:0]);
        dovf = (dv > 34'sd2147483647) || (dv < -34'sd2147483648);
        if (dv > 34'sd2147483647)       dres = 32'sh7fffffff;
        else if (dv < -34'sd2147483648) dres = 32'sh80000000;
        else                            dres = 32'(dv);
        if (dl_bz_reg[NumW])
        begin
            dres = '0;
            dovf = 1'b0;
        end
    end

    logic        done_reg;
    logic [31:0] res_reg;
    flags_t      flg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (is_div)
        begin
            res_reg <= dres;
            flg_reg <= '{is_less: 1'b0, is_equal: 1'b0, is_greater: 1'b0,
                         overflowed: dovf, divide_by_zero: dl_bz_reg[NumW]};
        end
        else
        begin
            res_reg <= dl_val_reg[Delay-1];
            flg_reg <= dl_flg_reg[Delay-1];
        end
    end

    logic unused_fv;
    assign unused_fv = f_valid;

    assign done           = done_reg;
    assign result_value   = res_reg;
    assign is_less        = flg_reg.is_less;
    assign is_equal       = flg_reg.is_equal;
    assign is_greater     = flg_reg.is_greater;
    assign overflowed     = flg_reg.overflowed;
    assign divide_by_zero = flg_reg.divide_by_zero;
endmodule

### rtl/fxalu_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
module fxalu_props (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [31:0] result_value,
    input logic        is_less,
    input logic        is_equal,
    input logic        is_greater,
    input logic        overflowed,
    input logic        divide_by_zero
);
    // At most one compare flag per beat.
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({is_less, is_equal, is_greater}))
        else $error("compare flags not exclusive");

    // Compare beats carry a zero value.
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (is_less || is_equal || is_greater)) |-> (result_value == '0))
        else $error("compare beat with nonzero value");

    // Divide by zero gives zero and no overflow.
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (result_value == '0 && !overflowed))
        else $error("divide by zero result wrong");

    // Overflow only at a saturation limit.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflowed) |->
            (result_value == 32'h7fffffff || result_value == 32'h80000000))
        else $error("overflow without saturated value");
endmodule

bind fixed_point_q24_8_alu_unit fxalu_props u_fxalu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .done           (done),
    .result_value   (result_value),
    .is_less        (is_less),
    .is_equal       (is_equal),
    .is_greater     (is_greater),
    .overflowed     (overflowed),
    .divide_by_zero (divide_by_zero)
);

### sim/fxalu_checker.sv
// Checker for the fixed-point ALU: predicts each result beat and compares it.
`timescale 1ns / 1ps
module fxalu_checker #(
    parameter int FRACTION_BITS = fxalu_pkg::FractionBitsDefault
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [3:0]                            command,
    input  logic signed [fxalu_pkg::DataWidth-1:0] operand_a,
    input  logic signed [fxalu_pkg::DataWidth-1:0] operand_b,
    input  logic                                  done,
    input  logic signed [fxalu_pkg::DataWidth-1:0] result_value,
    input  logic                                  is_less,
    input  logic                                  is_equal,
    input  logic                                  is_greater,
    input  logic                                  overflowed,
    input  logic                                  divide_by_zero,
    output int                                    errors,
    output int                                    pending
);
    import fxalu_pkg::*;

    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        flags_t                      flags;
    } alu_result_t;

    alu_result_t result_q[$];

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] saturate(input logic signed [127:0] v,
                                                   inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Expected result of one command beat.
    function automatic alu_result_t compute_alu(input logic [3:0] cmd,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        alu_result_t        res;
        logic signed [127:0] wa, wb, v;
        logic [127:0]        ma, mb, p, q, num;
        logic                neg;
        logic                ovf;
        wa = a;
        wb = b;
        ma = (wa < 0) ? -wa : wa;
        mb = (wb < 0) ? -wb : wb;
        neg = (a < 0) != (b < 0);
        ovf = 1'b0;
        res = '0;
        case (cmd)
            CMD_ADD: res.value = saturate(wa + wb, ovf);
            CMD_SUB: res.value = saturate(wa - wb, ovf);
            CMD_MUL:
            begin
                p = ma * mb;
                q = (p + (128'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
                v = neg ? -$signed(q) : $signed(q);
                res.value = saturate(v, ovf);
            end
            CMD_DIV:
            begin
                if (b == 0) begin
                    res.flags.divide_by_zero = 1'b1;
                end else begin
                    num = ma << FRACTION_BITS;
                    q = (2 * num + mb) / (2 * mb);
                    v = neg ? -$signed(q) : $signed(q);
                    res.value = saturate(v, ovf);
                end
            end
            CMD_CMP:
            begin
                res.flags.is_less = a < b;
                res.flags.is_equal = a == b;
                res.flags.is_greater = a > b;
            end
            CMD_MIN: res.value = (a < b) ? a : b;
            CMD_MAX: res.value = (a > b) ? a : b;
            CMD_INC: res.value = saturate(wa + 1, ovf);
            CMD_DEC: res.value = saturate(wa - 1, ovf);
            CMD_TO_INT:
            begin
                q = ma >> FRACTION_BITS;
                v = (a < 0) ? -$signed(q) : $signed(q);
                res.value = v[31:0];
            end
            CMD_FROM_INT: res.value = saturate(wa * (128'sd1 <<< FRACTION_BITS), ovf);
            default: res = '0;
        endcase
        res.flags.overflowed = ovf;
        return res;
    endfunction

    // Record expectations on accepted beats, compare results in order.
    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t seen, want;
        if (!rst_n) begin
            errors <= 0;
        end else begin
            if (done) begin
                seen.value = result_value;
                seen.flags = '{is_less, is_equal, is_greater, overflowed, divide_by_zero};
                if (result_q.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result beat: value=%h", result_value);
                    errors <= errors + 1;
                end else begin
                    want = result_q.pop_front();
                    if (seen !== want) begin
                        if (errors < 10)
                            $display("mismatch: exp value=%h flags=%b, got value=%h flags=%b",
                                     want.value, want.flags, seen.value, seen.flags);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                result_q.push_back(compute_alu(command, operand_a, operand_b));
        end
        pending = result_q.size();
    end

endmodule

### sim/tb_fixed_point_q24_8_alu_unit.sv
// Testbench top: drives command beats into the fixed-point ALU and reports.
`timescale 1ns / 1ps
module tb_fixed_point_q24_8_alu_unit;
    import fxalu_pkg::*;

    localparam int LATENCY = FractionBitsDefault + 36;
    localparam int CYCLE_LIMIT = 200000;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [3:0]                  command;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
    logic                        done;
    logic signed [DataWidth-1:0] result_value;
    logic                        is_less, is_equal, is_greater, overflowed, divide_by_zero;
    int                          errors;
    int                          pending;
    int                          cycles;

    fixed_point_q24_8_alu_unit dut (.*);

    fxalu_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog on total run length.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Random operand biased toward edges and small values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
            3: return $signed(16'($urandom()));
            4: return $signed(24'($urandom()));
            default: return $urandom();
        endcase
    endfunction

    // Drive one beat, holding until accepted; idle gaps optional.
    task automatic issue_beat(input logic [3:0] cmd, input logic [31:0] a,
                              input logic [31:0] b, input bit gaps);
        while (gaps && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [3:0] cmd;
        start = 1'b0;
        command = '0;
        operand_a = '0;
        operand_b = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every command at field extremes, zero divisor, halves, unknown codes.
        issue_beat(CMD_ADD, 32'h7FFF_FFFF, 32'd1, 0);
        issue_beat(CMD_SUB, 32'h8000_0000, 32'd1, 0);
        issue_beat(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0);
        issue_beat(CMD_MUL, 32'd1, 32'h80, 0);
        issue_beat(CMD_MUL, 32'hFFFF_FFFF, 32'h80, 0);
        issue_beat(CMD_DIV, 32'h1234, 32'd0, 0);
        issue_beat(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        issue_beat(CMD_DIV, 32'd1, 32'd512, 0);
        issue_beat(CMD_DIV, 32'hFFFF_FFFF, 32'd512, 0);
        issue_beat(CMD_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        issue_beat(CMD_CMP, 32'd5, 32'd5, 0);
        issue_beat(CMD_CMP, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        issue_beat(CMD_MIN, 32'd7, 32'd7, 0);
        issue_beat(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        issue_beat(CMD_INC, 32'h7FFF_FFFF, 32'd0, 0);
        issue_beat(CMD_DEC, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        issue_beat(CMD_TO_INT, 32'hFFFF_FF01, 32'd0, 0);
        issue_beat(CMD_TO_INT, 32'h8000_0000, 32'd0, 0);
        issue_beat(CMD_FROM_INT, 32'h0080_0000, 32'd0, 0);
        issue_beat(CMD_FROM_INT, 32'hFF80_0000, 32'd0, 0);
        issue_beat(4'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue_beat(4'd15, 32'h1, 32'h1, 0);

        // Hold off until the pipeline drains.
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        // Random beats; the middle stretch runs back to back.
        for (int i = 0; i < 550; i++)
        begin
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
            issue_beat(cmd, pick_operand(), pick_operand(), !(i >= 200 && i < 300));
        end
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
